### src/color_point_pair_feature_defines.svh
`ifndef COLOR_POINT_PAIR_FEATURE_DEFINES_SVH
`define COLOR_POINT_PAIR_FEATURE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CPPF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define CPPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cppf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cppf_pkg;

    localparam int POS_W       = 20;
    localparam int DL_W        = POS_W + 1;
    localparam int NRM_W       = 16;
    localparam int COL_W       = 8;
    localparam int COLOR_W     = 3 * COL_W;
    localparam int NORMAL_W    = 3 * NRM_W;
    localparam int SQ_W        = 2 * DL_W - 1;
    localparam int S_W         = SQ_W + 1;
    localparam int PROD_W      = NRM_W + DL_W;
    localparam int DOT_W       = PROD_W + 2;
    localparam int MAG_W       = DOT_W - 1;
    localparam int HALF_W      = MAG_W / 2;
    localparam int M_W         = 2 * MAG_W + 4;
    localparam int P_W         = M_W + 2;
    localparam int QS_W        = 61;
    localparam int PNN_W       = 2 * NRM_W;
    localparam int DOTN_W      = PNN_W + 2;
    localparam int COS_W       = 16;
    localparam int COS_ONE     = 16384;
    localparam int COS_FRAC    = 14;
    localparam int DIST_W      = 21;
    localparam int HUE_W       = 16;
    localparam int SV_W        = 17;

    localparam int COS_STEPS   = 15;
    localparam int DIV_STEPS   = SV_W;
    localparam int ISQRT_STEPS = 21;
    localparam int COS_LAT     = COS_STEPS + 4;
    localparam int HSV_LAT     = DIV_STEPS + 3;
    localparam int FRONT_LAT   = 3;
    localparam int ALIGN       = FRONT_LAT + ISQRT_STEPS;

    localparam int PT_W        = 3 * POS_W + NORMAL_W + COLOR_W;
    localparam int IN_W        = 2 * PT_W;
    localparam int OUT_FIELD_W = 3 * COS_W + DIST_W + 2 * (HUE_W + 2 * SV_W);
    localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SV_W-1:0]  sat;
        logic [SV_W-1:0]  val;
    } hsv_t;

endpackage

`default_nettype wire

### src/color_point_pair_feature.sv
// color point pair feature
//
// s_tdata carries one point pair a word; one word of ten features leaves on
// m_tdata with the coincident flag on m_tuser. both channels move a word on
// a cycle where tvalid and tready are high.
//
// an accepted word passes through 3 front stages to m_tvalid
// (deltas, products, sums), the 21-stage square root for the distance and one
// output register, the first loaded at the accepting edge. the cosine search
// (19 stages) and the color units (20 stages) run beside the square root.
// throughput is one word per cycle while s_tready stays high.
//
// when the receiver holds m_tready low the output register keeps its word;
// the pipeline keeps taking words until a finished word reaches its last
// stage, then s_tready drops until the output register is taken. nothing is
// dropped or repeated. reset clears all valid flags and the output valid;
// the block takes words in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "color_point_pair_feature_defines.svh"

module color_point_pair_feature (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // first_x, first_y, first_z, first_normal, first_color, second_x,
    // second_y, second_z, second_normal, second_color
    input  wire logic [cppf_pkg::IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // cos_first_normal_dir, cos_second_normal_dir, cos_between_normals,
    // distance, first_hue, first_saturation, first_value, second_hue,
    // second_saturation, second_value, zero pad
    output logic      [cppf_pkg::OUT_W-1:0]    m_tdata,
    // coincident
    output logic                               m_tuser
);

    localparam int POS_W  = cppf_pkg::POS_W;
    localparam int DL_W   = cppf_pkg::DL_W;
    localparam int NRM_W  = cppf_pkg::NRM_W;
    localparam int PT_W   = cppf_pkg::PT_W;
    localparam int ALIGN  = cppf_pkg::ALIGN;
    localparam int COS_W  = cppf_pkg::COS_W;
    localparam int HSV_W  = $bits(cppf_pkg::hsv_t);
    localparam int NRM_LO = 3 * POS_W;
    localparam int COL_LO = NRM_LO + cppf_pkg::NORMAL_W;

    logic en;
    logic out_load;
    logic [ALIGN-1:0] vld_reg;

    // stage 1: deltas and unpacked normals
    logic signed [DL_W-1:0]  dl_reg [0:2];
    logic signed [NRM_W-1:0] n1_reg [0:2];
    logic signed [NRM_W-1:0] n2_reg [0:2];
    logic [cppf_pkg::COLOR_W-1:0] col1_reg, col2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dl_reg[i] <= $signed(DL_W'($signed(s_tdata[PT_W+POS_W*i +: POS_W])))
                           - $signed(DL_W'($signed(s_tdata[POS_W*i +: POS_W])));
                n1_reg[i] <= $signed(s_tdata[NRM_LO+NRM_W*i +: NRM_W]);
                n2_reg[i] <= $signed(s_tdata[PT_W+NRM_LO+NRM_W*i +: NRM_W]);
            end
            col1_reg <= s_tdata[COL_LO +: cppf_pkg::COLOR_W];
            col2_reg <= s_tdata[PT_W+COL_LO +: cppf_pkg::COLOR_W];
        end
    end

    // stage 2: products
    logic        [cppf_pkg::SQ_W-1:0]   sq_reg  [0:2];
    logic signed [cppf_pkg::PROD_W-1:0] pd1_reg [0:2];
    logic signed [cppf_pkg::PROD_W-1:0] pd2_reg [0:2];
    logic signed [cppf_pkg::PNN_W-1:0]  pnn_reg [0:2];
    logic signed [2*DL_W-1:0]           sq_full [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_full[i] = dl_reg[i] * dl_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]  <= sq_full[i][cppf_pkg::SQ_W-1:0];
                pd1_reg[i] <= n1_reg[i] * dl_reg[i];
                pd2_reg[i] <= n2_reg[i] * dl_reg[i];
                pnn_reg[i] <= n1_reg[i] * n2_reg[i];
            end
        end
    end

    // stage 3: sums
    logic        [cppf_pkg::S_W-1:0]    s_reg;
    logic signed [cppf_pkg::DOT_W-1:0]  dot1_reg, dot2_reg;
    logic signed [cppf_pkg::DOTN_W-1:0] dotn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= cppf_pkg::S_W'(sq_reg[0]) + cppf_pkg::S_W'(sq_reg[1])
                      + cppf_pkg::S_W'(sq_reg[2]);
            dot1_reg <= cppf_pkg::DOT_W'(pd1_reg[0]) + cppf_pkg::DOT_W'(pd1_reg[1])
                      + cppf_pkg::DOT_W'(pd1_reg[2]);
            dot2_reg <= cppf_pkg::DOT_W'(pd2_reg[0]) + cppf_pkg::DOT_W'(pd2_reg[1])
                      + cppf_pkg::DOT_W'(pd2_reg[2]);
            dotn_reg <= cppf_pkg::DOTN_W'(pnn_reg[0]) + cppf_pkg::DOTN_W'(pnn_reg[1])
                      + cppf_pkg::DOTN_W'(pnn_reg[2]);
        end
    end

    // stage 4: normal-normal cosine and coincidence
    logic [COS_W:0]                    cosn_reg;
    logic [cppf_pkg::DOTN_W-1:0]       dotn_abs;
    logic [cppf_pkg::DOTN_W-1:0]       dotn_rnd;
    logic [COS_W-1:0]                  cosn_mag;

    always_comb
    begin
        dotn_abs = dotn_reg[cppf_pkg::DOTN_W-1] ? -dotn_reg : dotn_reg;
        dotn_rnd = (dotn_abs + (cppf_pkg::DOTN_W'(1) << (cppf_pkg::COS_FRAC - 1)))
                   >> cppf_pkg::COS_FRAC;
        if (dotn_rnd > cppf_pkg::DOTN_W'(cppf_pkg::COS_ONE))
        begin
            cosn_mag = COS_W'(cppf_pkg::COS_ONE);
        end
        else
        begin
            cosn_mag = dotn_rnd[COS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cosn_reg[COS_W-1:0] <= dotn_reg[cppf_pkg::DOTN_W-1] ? -cosn_mag : cosn_mag;
            cosn_reg[COS_W]     <= s_reg == '0;
        end
    end

    // feature units
    logic signed [COS_W-1:0] cos1, cos2;
    logic [cppf_pkg::DIST_W-1:0] dist_root;
    cppf_pkg::hsv_t hsv1, hsv2;

    cppf_cos u_cos1 (
        .clk (clk),
        .en  (en),
        .dot (dot1_reg),
        .rad (s_reg),
        .cos (cos1)
    );

    cppf_cos u_cos2 (
        .clk (clk),
        .en  (en),
        .dot (dot2_reg),
        .rad (s_reg),
        .cos (cos2)
    );

    cppf_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (s_reg),
        .root (dist_root)
    );

    cppf_hsv u_hsv1 (
        .clk   (clk),
        .en    (en),
        .color (col1_reg),
        .res   (hsv1)
    );

    cppf_hsv u_hsv2 (
        .clk   (clk),
        .en    (en),
        .color (col2_reg),
        .res   (hsv2)
    );

    // alignment to the square root output
    logic [2*COS_W-1:0] cos_dly;
    logic [2*HSV_W-1:0] hsv_dly;
    logic [COS_W:0]     cosn_dly;

    cppf_delay #(
        .WIDTH (2 * COS_W),
        .DEPTH (ALIGN - cppf_pkg::FRONT_LAT - cppf_pkg::COS_LAT)
    ) u_cos_dly (
        .clk      (clk),
        .en       (en),
        .data_in  ({cos2, cos1}),
        .data_out (cos_dly)
    );

    cppf_delay #(
        .WIDTH (2 * HSV_W),
        .DEPTH (ALIGN - 1 - cppf_pkg::HSV_LAT)
    ) u_hsv_dly (
        .clk      (clk),
        .en       (en),
        .data_in  ({hsv2, hsv1}),
        .data_out (hsv_dly)
    );

    cppf_delay #(
        .WIDTH (COS_W + 1),
        .DEPTH (ALIGN - cppf_pkg::FRONT_LAT - 1)
    ) u_cosn_dly (
        .clk      (clk),
        .en       (en),
        .data_in  (cosn_reg),
        .data_out (cosn_dly)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ALIGN-2:0], s_tvalid};
        end
    end

    assign out_load = !m_tvalid || m_tready;
    assign en       = !vld_reg[ALIGN-1] || out_load;
    assign s_tready = en;

    // output register
    logic [cppf_pkg::OUT_W-1:0] out_data_reg;
    logic [cppf_pkg::OUT_W-1:0] out_data_next;
    logic                       out_coinc_reg;
    logic                       out_valid_reg;
    cppf_pkg::hsv_t             h1, h2;
    logic                       coinc;

    always_comb
    begin
        h1    = hsv_dly[HSV_W-1:0];
        h2    = hsv_dly[2*HSV_W-1:HSV_W];
        coinc = cosn_dly[COS_W];
        out_data_next = cppf_pkg::OUT_W'({
            h2.val, h2.sat, h2.hue,
            h1.val, h1.sat, h1.hue,
            dist_root,
            cosn_dly[COS_W-1:0],
            coinc ? {COS_W{1'b0}} : cos_dly[2*COS_W-1:COS_W],
            coinc ? {COS_W{1'b0}} : cos_dly[COS_W-1:0]
        });
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= vld_reg[ALIGN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg  <= out_data_next;
            out_coinc_reg <= coinc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_coinc_reg;

    `CPPF_ASSERT_SAME(a_stall_cause, !s_tready,
        vld_reg[ALIGN-1] && m_tvalid && !m_tready, "input stalled without a held result")
    `CPPF_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_reg[0],
        "accepted word lost at entry")
    `CPPF_ASSERT_SAME(a_coinc_zero, m_tvalid && m_tuser,
        m_tdata[31:0] == 32'd0 && m_tdata[68:48] == 21'd0,
        "coincident word with nonzero direction terms")
    `CPPF_ASSERT_SAME(a_cos_range, m_tvalid,
        $signed(m_tdata[47:32]) <= 16'sd16384 && $signed(m_tdata[47:32]) >= -16'sd16384,
        "normal cosine out of range")

endmodule

`default_nettype wire

### src/cppf_delay.sv
`timescale 1ns / 1ps
`default_nettype none

module cppf_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] data_in,
    output logic      [WIDTH-1:0] data_out
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= data_in;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign data_out = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

### src/cppf_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module cppf_isqrt (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [cppf_pkg::S_W-1:0]     rad,
    output logic      [cppf_pkg::DIST_W-1:0]  root
);

    localparam int STEPS = cppf_pkg::ISQRT_STEPS;
    localparam int RW    = cppf_pkg::S_W + 1;

    logic [RW-1:0] rem_reg  [0:STEPS-1];
    logic [RW-1:0] root_reg [0:STEPS-1];

    // one result bit per stage
    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        localparam int K = STEPS - 1 - j;
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * K);

        logic [RW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (j == 0)
        begin : g_first
            assign rem_in  = RW'(rad);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        always_comb
        begin
            trial = root_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = (root_in >> 1) + BIT;
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign root = root_reg[STEPS-1][cppf_pkg::DIST_W-1:0];

endmodule

`default_nettype wire

### src/cppf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module cppf_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 9,
    parameter int QUO_W = 17
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [QUO_W-1:0] quo
);

    localparam int RW = DEN_W + QUO_W;

    logic [RW-1:0]    rem_reg [0:QUO_W-1];
    logic [QUO_W-1:0] quo_reg [0:QUO_W-1];
    logic [DEN_W-1:0] den_reg [0:QUO_W-1];

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_step
        localparam int K = QUO_W - 1 - j;

        logic [RW-1:0]    rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W-1:0] den_in;
        logic [RW-1:0]    sub;
        logic [RW-1:0]    rem_next;
        logic [QUO_W-1:0] quo_next;

        if (j == 0)
        begin : g_first
            assign rem_in = RW'(num);
            assign quo_in = '0;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign den_in = den_reg[j-1];
        end

        always_comb
        begin
            sub = RW'(den_in) << K;
            if (rem_in >= sub)
            begin
                rem_next = rem_in - sub;
                quo_next = quo_in | (QUO_W'(1) << K);
            end
            else
            begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                quo_reg[j] <= quo_next;
                den_reg[j] <= den_in;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

### src/cppf_cos.sv
`timescale 1ns / 1ps
`default_nettype none

module cppf_cos (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [cppf_pkg::DOT_W-1:0] dot,
    input  wire logic        [cppf_pkg::S_W-1:0]   rad,
    output logic signed      [cppf_pkg::COS_W-1:0] cos
);

    localparam int STEPS  = cppf_pkg::COS_STEPS;
    localparam int MAG_W  = cppf_pkg::MAG_W;
    localparam int HALF_W = cppf_pkg::HALF_W;
    localparam int M_W    = cppf_pkg::M_W;
    localparam int P_W    = cppf_pkg::P_W;
    localparam int QS_W   = cppf_pkg::QS_W;
    localparam int S_W    = cppf_pkg::S_W;
    localparam int COS_W  = cppf_pkg::COS_W;

    // magnitude and sign
    logic             neg1_reg;
    logic [MAG_W-1:0] mag1_reg;
    logic [S_W-1:0]   s1_reg;
    logic [cppf_pkg::DOT_W-1:0] abs_next;

    always_comb
    begin
        abs_next = dot[cppf_pkg::DOT_W-1] ? -dot : dot;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= dot[cppf_pkg::DOT_W-1];
            mag1_reg <= abs_next[MAG_W-1:0];
            s1_reg   <= rad;
        end
    end

    // partial products of the squared magnitude
    logic [2*HALF_W-1:0] hh_reg;
    logic [2*HALF_W-1:0] hl_reg;
    logic [2*HALF_W-1:0] ll_reg;
    logic                neg2_reg;
    logic [S_W-1:0]      s2_reg;
    logic [HALF_W-1:0]   mag_hi;
    logic [HALF_W-1:0]   mag_lo;

    assign mag_hi = mag1_reg[MAG_W-1:HALF_W];
    assign mag_lo = mag1_reg[HALF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg   <= mag_hi * mag_hi;
            hl_reg   <= mag_hi * mag_lo;
            ll_reg   <= mag_lo * mag_lo;
            neg2_reg <= neg1_reg;
            s2_reg   <= s1_reg;
        end
    end

    // search state: p = t*t*s, q = t*s with t = 2c - 1, bound m = 4*mag*mag
    logic signed [P_W-1:0]   p_reg   [0:STEPS];
    logic signed [QS_W-1:0]  q_reg   [0:STEPS];
    logic        [M_W-1:0]   m_reg   [0:STEPS];
    logic        [S_W-1:0]   s_reg   [0:STEPS];
    logic        [STEPS-1:0] c_reg   [0:STEPS];
    logic                    neg_reg [0:STEPS];
    logic        [M_W-1:0]   m_next;

    always_comb
    begin
        m_next = (M_W'(hh_reg) << (2 * HALF_W + 2))
               + (M_W'(hl_reg) << (HALF_W + 3))
               + (M_W'(ll_reg) << 2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]   <= $signed(P_W'(s2_reg));
            q_reg[0]   <= -$signed(QS_W'(s2_reg));
            m_reg[0]   <= m_next;
            s_reg[0]   <= s2_reg;
            c_reg[0]   <= '0;
            neg_reg[0] <= neg2_reg;
        end
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_step
        localparam int K = STEPS - 1 - j;

        logic signed [P_W-1:0]   pt;
        logic signed [QS_W-1:0]  qt;
        logic                    fits;
        logic signed [P_W-1:0]   p_next;
        logic signed [QS_W-1:0]  q_next;
        logic        [STEPS-1:0] c_next;

        always_comb
        begin
            pt     = p_reg[j] + (P_W'(q_reg[j]) <<< (K + 2))
                   + $signed(P_W'(s_reg[j]) << (2 * K + 2));
            qt     = q_reg[j] + $signed(QS_W'(s_reg[j]) << (K + 1));
            fits   = pt <= $signed(P_W'(m_reg[j]));
            p_next = fits ? pt : p_reg[j];
            q_next = fits ? qt : q_reg[j];
            c_next = fits ? (c_reg[j] | (STEPS'(1) << K)) : c_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[j+1]   <= p_next;
                q_reg[j+1]   <= q_next;
                m_reg[j+1]   <= m_reg[j];
                s_reg[j+1]   <= s_reg[j];
                c_reg[j+1]   <= c_next;
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    // clamp to one and restore sign
    logic signed [COS_W-1:0] cos_reg;
    logic        [COS_W-1:0] capped;

    always_comb
    begin
        if (c_reg[STEPS] > STEPS'(cppf_pkg::COS_ONE))
        begin
            capped = COS_W'(cppf_pkg::COS_ONE);
        end
        else
        begin
            capped = COS_W'(c_reg[STEPS]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[STEPS] ? -$signed(capped) : $signed(capped);
        end
    end

    assign cos = cos_reg;

endmodule

`default_nettype wire

### src/cppf_hsv.sv
`timescale 1ns / 1ps
`default_nettype none

module cppf_hsv (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [cppf_pkg::COLOR_W-1:0]    color,
    output cppf_pkg::hsv_t                       res
);

    localparam int COL_W     = cppf_pkg::COL_W;
    localparam int SV_W      = cppf_pkg::SV_W;
    localparam int HUE_W     = cppf_pkg::HUE_W;
    localparam int QUO_W     = cppf_pkg::DIV_STEPS;
    localparam int N_W       = 12;
    localparam int HNUM_W    = N_W - 1 + QUO_W;
    localparam int HDEN_W    = N_W;
    localparam int SNUM_W    = COL_W + QUO_W;
    localparam int SDEN_W    = COL_W + 1;
    localparam int FLAG_W    = 2 + SV_W;

    // channel max and min
    logic [COL_W-1:0] r_reg, g_reg, b_reg, mx_reg, d_reg;
    logic             rmax_reg, gmax_reg;
    logic [COL_W-1:0] r_in, g_in, b_in, mx_in, mn_in;
    logic             rmax_in, gmax_in;

    always_comb
    begin
        r_in    = color[3*COL_W-1:2*COL_W];
        g_in    = color[2*COL_W-1:COL_W];
        b_in    = color[COL_W-1:0];
        rmax_in = (r_in >= g_in) && (r_in >= b_in);
        gmax_in = !rmax_in && (g_in >= b_in);
        mx_in   = rmax_in ? r_in : (gmax_in ? g_in : b_in);
        mn_in   = r_in;
        if (g_in < mn_in)
        begin
            mn_in = g_in;
        end
        if (b_in < mn_in)
        begin
            mn_in = b_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= r_in;
            g_reg    <= g_in;
            b_reg    <= b_in;
            mx_reg   <= mx_in;
            d_reg    <= mx_in - mn_in;
            rmax_reg <= rmax_in;
            gmax_reg <= gmax_in;
        end
    end

    // divider operands
    logic [HNUM_W-1:0] hnum_reg;
    logic [HDEN_W-1:0] hden_reg;
    logic [SNUM_W-1:0] snum_reg;
    logic [SDEN_W-1:0] sden_reg;
    logic [FLAG_W-1:0] flag_reg;
    logic [N_W-1:0]    d12, r12, g12, b12, n_w, six_d;

    always_comb
    begin
        d12   = N_W'(d_reg);
        r12   = N_W'(r_reg);
        g12   = N_W'(g_reg);
        b12   = N_W'(b_reg);
        six_d = (d12 << 2) + (d12 << 1);
        if (rmax_reg)
        begin
            n_w = g12 - b12;
            if (g_reg < b_reg)
            begin
                n_w = n_w + six_d;
            end
        end
        else if (gmax_reg)
        begin
            n_w = (d12 << 1) + b12 - r12;
        end
        else
        begin
            n_w = (d12 << 2) + r12 - g12;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hnum_reg <= {n_w[N_W-2:0], {QUO_W{1'b0}}} + HNUM_W'(six_d);
            hden_reg <= (d12 << 3) + (d12 << 2);
            snum_reg <= {d_reg, {QUO_W{1'b0}}} | SNUM_W'(mx_reg);
            sden_reg <= {mx_reg, 1'b0};
            // flags: value, no chroma, black
            flag_reg <= {{1'b0, mx_reg, mx_reg} + SV_W'(mx_reg[COL_W-1]),
                         d_reg == '0, mx_reg == '0};
        end
    end

    logic [QUO_W-1:0]  hquo, squo;
    logic [FLAG_W-1:0] flag_dly;

    cppf_div #(
        .NUM_W (HNUM_W),
        .DEN_W (HDEN_W),
        .QUO_W (QUO_W)
    ) u_hue_div (
        .clk (clk),
        .en  (en),
        .num (hnum_reg),
        .den (hden_reg),
        .quo (hquo)
    );

    cppf_div #(
        .NUM_W (SNUM_W),
        .DEN_W (SDEN_W),
        .QUO_W (QUO_W)
    ) u_sat_div (
        .clk (clk),
        .en  (en),
        .num (snum_reg),
        .den (sden_reg),
        .quo (squo)
    );

    cppf_delay #(
        .WIDTH (FLAG_W),
        .DEPTH (QUO_W)
    ) u_flag_dly (
        .clk      (clk),
        .en       (en),
        .data_in  (flag_reg),
        .data_out (flag_dly)
    );

    // special colors and hue clamp
    cppf_pkg::hsv_t res_reg;
    cppf_pkg::hsv_t res_next;

    always_comb
    begin
        res_next.val = flag_dly[FLAG_W-1:2];
        if (flag_dly[1] || flag_dly[0])
        begin
            res_next.hue = '0;
        end
        else if (hquo[QUO_W-1])
        begin
            res_next.hue = '1;
        end
        else
        begin
            res_next.hue = hquo[HUE_W-1:0];
        end
        res_next.sat = flag_dly[0] ? '0 : squo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire
